// ----- sv/light_trend_deploy_sequencer_macros.svh -----
// Assertion macros for the light trend deploy sequencer.
// Included by the top level; no other dependencies.
`ifndef LIGHT_TREND_DEPLOY_SEQUENCER_MACROS_SVH
`define LIGHT_TREND_DEPLOY_SEQUENCER_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define LTD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ltd: same-cycle check failed");

// Next-cycle implication, disabled while reset is high
`define LTD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ltd: next-cycle check failed");

`endif

// ----- sv/ltd_pkg.sv -----
// Shared types, codes and width helpers for the light trend deploy sequencer.
// No dependencies; the design modules refer to it by scoped names.
package ltd_pkg;

   localparam int WINDOW_LEN_DEF = 6;
   localparam int LUX_W          = 16;
   localparam int LOW_LIGHT_W    = 16;
   localparam int CRIT_T2_W      = 24;
   localparam int Q_SHIFT        = 16;
   localparam int MUL_W          = 32;
   localparam int REQ_DATA_W     = 16;
   localparam int RSP_DATA_W     = 8;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 24;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LOW_LIGHT = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CRIT_T2   = 2'd1;

   localparam logic [LOW_LIGHT_W-1:0] LOW_LIGHT_RESET = 16'd10;
   localparam logic [CRIT_T2_W-1:0]   CRIT_T2_RESET   = 24'd505194;

   typedef enum logic [1:0] {
      TREND_TRAINING = 2'd0,
      TREND_FALLING  = 2'd1,
      TREND_STEADY   = 2'd2,
      TREND_RISING   = 2'd3
   } trend_type;

   typedef enum logic [1:0] {
      PHASE_LOADING   = 2'd0,
      PHASE_WAITING   = 2'd1,
      PHASE_DEPLOYING = 2'd2,
      PHASE_FINISHED  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      MAC_HOLD = 2'd0,
      MAC_LOAD = 2'd1,
      MAC_ADD  = 2'd2,
      MAC_SUB  = 2'd3
   } mac_mode_type;

   // Multiplier step: what to do with the product, and whether it is the upper half
   typedef struct packed {
      mac_mode_type mode;
      logic         hi;
   } mac_ctrl_type;

   // Window moves: shift a new sample in, or rotate one place for a sum pass
   typedef struct packed {
      logic push;
      logic rotate;
   } win_ctrl_type;

   // Accumulator width: holds ct2 * Q * (n*Syy - Sy^2) with a sign bit to spare
   function automatic int acc_width(input int n);
      int syy_w;
      int x_w;
      int q;
      int qx_w;
      syy_w = 2 * LUX_W + $clog2(n + 1);
      x_w   = syy_w + $clog2(n + 1);
      q     = n * n * (n * n - 1) / 12;
      qx_w  = x_w + $clog2(q + 1);
      return CRIT_T2_W + qx_w + 1;
   endfunction

endpackage

// ----- sv/ltd_window.sv -----
// Sliding window of the last WINDOW_LEN light samples, oldest at tap 0.
// Uses ltd_pkg for the control struct and sample width.
module ltd_window #(
   parameter int WINDOW_LEN = ltd_pkg::WINDOW_LEN_DEF
) (
   input  logic                       clock,
   input  ltd_pkg::win_ctrl_type      ctrl,
   input  logic [ltd_pkg::LUX_W-1:0]  din,
   output logic [ltd_pkg::LUX_W-1:0]  tail
);

   logic [ltd_pkg::LUX_W-1:0] tap_ff [WINDOW_LEN];

   // Push drops the oldest tap; rotate walks the newest tap around to the front
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         for (int i = 0; i < WINDOW_LEN - 1; i++) begin
            tap_ff[i] <= tap_ff[i + 1];
         end
         tap_ff[WINDOW_LEN - 1] <= din;
      end else if (ctrl.rotate) begin
         tap_ff[0] <= tap_ff[WINDOW_LEN - 1];
         for (int i = 1; i < WINDOW_LEN; i++) begin
            tap_ff[i] <= tap_ff[i - 1];
         end
      end
   end

   assign tail = tap_ff[WINDOW_LEN - 1];

endmodule

// ----- sv/ltd_mac.sv -----
// Shared 32x32 multiplier with a wide load/add/subtract accumulator.
// Uses ltd_pkg for the step control struct and operand width.
module ltd_mac #(
   parameter int ACC_W = ltd_pkg::acc_width(ltd_pkg::WINDOW_LEN_DEF)
) (
   input  logic                       clock,
   input  ltd_pkg::mac_ctrl_type      ctrl,
   input  logic [ltd_pkg::MUL_W-1:0]  op_a,
   input  logic [ltd_pkg::MUL_W-1:0]  op_b,
   output logic [ACC_W-1:0]           acc
);

   logic [2*ltd_pkg::MUL_W-1:0] prod;
   logic [ACC_W-1:0]            term;
   logic [ACC_W-1:0]            acc_ff;
   logic [ACC_W-1:0]            acc_in;

   assign prod = op_a * op_b;

   // Upper-half products land one word up
   assign term = ctrl.hi ? ACC_W'({prod, {ltd_pkg::MUL_W{1'b0}}}) : ACC_W'(prod);

   always_comb begin
      unique case (ctrl.mode)
         ltd_pkg::MAC_LOAD: acc_in = term;
         ltd_pkg::MAC_ADD:  acc_in = acc_ff + term;
         ltd_pkg::MAC_SUB:  acc_in = acc_ff - term;
         default:           acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- sv/ltd_trend.sv -----
// Slope t-test sequencer: window sums, then the exact integer significance test.
// Drives ltd_mac and the window rotation; uses ltd_pkg types and width helpers.
module ltd_trend #(
   parameter int WINDOW_LEN = ltd_pkg::WINDOW_LEN_DEF,
   parameter int ACC_W      = ltd_pkg::acc_width(ltd_pkg::WINDOW_LEN_DEF)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ltd_pkg::LUX_W-1:0]      y,
   input  logic [ltd_pkg::CRIT_T2_W-1:0]  crit_t2,
   input  logic [ACC_W-1:0]               acc,
   output logic                           rotate,
   output ltd_pkg::mac_ctrl_type          mac_ctrl,
   output logic [ltd_pkg::MUL_W-1:0]      op_a,
   output logic [ltd_pkg::MUL_W-1:0]      op_b,
   output logic                           done,
   output ltd_pkg::trend_type             trend
);

   localparam int N      = WINDOW_LEN;
   localparam int JW     = $clog2(N);
   localparam int SUMX   = N * (N - 1) / 2;
   localparam int QF     = N * N * (N * N - 1) / 12;
   localparam int SY_W   = ltd_pkg::LUX_W + $clog2(N + 1);
   localparam int SXY_W  = ltd_pkg::LUX_W + $clog2(SUMX + 1);
   localparam int SYY_W  = 2 * ltd_pkg::LUX_W + $clog2(N + 1);
   localparam int X_W    = SYY_W + $clog2(N + 1);
   localparam int R_W    = X_W + $clog2(QF + 1);
   localparam int DMAG_W = ltd_pkg::LUX_W + $clog2(N * SUMX + 1);
   localparam int MW     = ltd_pkg::MUL_W;
   localparam int CMP_W  = ACC_W + ltd_pkg::Q_SHIFT;

   localparam logic [MW-1:0] N_OP    = MW'(N);
   localparam logic [MW-1:0] SUMX_OP = MW'(SUMX);
   localparam logic [MW-1:0] Q_OP    = MW'(QF);
   localparam logic [MW-1:0] NM2_OP  = MW'(N - 2);
   localparam logic [JW-1:0] J_LAST  = JW'(N - 1);

   typedef enum logic [3:0] {
      T_IDLE, T_ACC, T_MV, T_D1, T_D2, T_X1, T_X2, T_X3,
      T_Q1, T_Q2, T_Q3, T_L0, T_L1, T_L2, T_L3
   } tstate_type;

   tstate_type          state_ff, state_in;
   logic [JW-1:0]       j_ff, j_in;
   logic [SY_W-1:0]     sy_ff, sy_in;
   logic [SXY_W-1:0]    sxy_ff, sxy_in;
   logic [SYY_W-1:0]    syy_ff, syy_in;
   logic [X_W-1:0]      x_ff, x_in;
   logic [R_W-1:0]      r_ff, r_in;
   logic [DMAG_W-1:0]   dmag_ff, dmag_in;
   logic                dneg_ff, dneg_in;
   logic [ACC_W-1:0]    rhs_ff, rhs_in;

   logic [SY_W-1:0]     sy_sum;
   logic [ACC_W-1:0]    acc_neg;
   logic                acc_sign;
   logic [63:0]         syy64;
   logic [63:0]         x64;
   logic [63:0]         r64;
   logic [CMP_W-1:0]    lhs_cmp;
   logic [CMP_W-1:0]    rhs_cmp;
   logic                significant;

   assign sy_sum   = sy_ff + SY_W'(y);
   assign acc_neg  = -acc;
   assign acc_sign = acc[ACC_W-1];
   assign syy64    = 64'(syy_ff);
   assign x64      = 64'(x_ff);
   assign r64      = 64'(r_ff);

   // Slope is significant when (n-2)*D^2 * 2^16 beats t^2 * R
   assign lhs_cmp     = {acc, {ltd_pkg::Q_SHIFT{1'b0}}};
   assign rhs_cmp     = CMP_W'(rhs_ff);
   assign significant = lhs_cmp > rhs_cmp;

   always_comb begin
      if (!significant) begin
         trend = ltd_pkg::TREND_STEADY;
      end else if (dneg_ff) begin
         trend = ltd_pkg::TREND_FALLING;
      end else begin
         trend = ltd_pkg::TREND_RISING;
      end
   end

   // Step sequencer: one multiplier operation per step, then a compare step
   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      sy_in         = sy_ff;
      sxy_in        = sxy_ff;
      syy_in        = syy_ff;
      x_in          = x_ff;
      r_in          = r_ff;
      dmag_in       = dmag_ff;
      dneg_in       = dneg_ff;
      rhs_in        = rhs_ff;
      rotate        = 1'b0;
      done          = 1'b0;
      mac_ctrl.mode = ltd_pkg::MAC_HOLD;
      mac_ctrl.hi   = 1'b0;
      op_a          = '0;
      op_b          = '0;
      unique case (state_ff)
         T_IDLE: begin
            if (start) begin
               j_in     = '0;
               sy_in    = '0;
               sxy_in   = '0;
               state_in = T_ACC;
            end
         end
         // Newest sample first: Sy is the running suffix sum, Sxy adds each
         // suffix sum except the full one, Syy collects in the accumulator
         T_ACC: begin
            rotate        = 1'b1;
            op_a          = MW'(y);
            op_b          = MW'(y);
            mac_ctrl.mode = (j_ff == '0) ? ltd_pkg::MAC_LOAD : ltd_pkg::MAC_ADD;
            sy_in         = sy_sum;
            if (j_ff != J_LAST) begin
               sxy_in = sxy_ff + SXY_W'(sy_sum);
               j_in   = j_ff + JW'(1);
            end else begin
               state_in = T_MV;
            end
         end
         // Park Syy, start D = n*Sxy - SUMX*Sy
         T_MV: begin
            syy_in        = SYY_W'(acc);
            op_a          = MW'(sxy_ff);
            op_b          = N_OP;
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_D1;
         end
         T_D1: begin
            op_a          = MW'(sy_ff);
            op_b          = SUMX_OP;
            mac_ctrl.mode = ltd_pkg::MAC_SUB;
            state_in      = T_D2;
         end
         // Split D into sign and magnitude, start n*Syy
         T_D2: begin
            dneg_in       = acc_sign;
            dmag_in       = acc_sign ? DMAG_W'(acc_neg) : DMAG_W'(acc);
            op_a          = syy64[31:0];
            op_b          = N_OP;
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_X1;
         end
         T_X1: begin
            op_a          = syy64[63:32];
            op_b          = N_OP;
            mac_ctrl.mode = ltd_pkg::MAC_ADD;
            mac_ctrl.hi   = 1'b1;
            state_in      = T_X2;
         end
         T_X2: begin
            op_a          = MW'(sy_ff);
            op_b          = MW'(sy_ff);
            mac_ctrl.mode = ltd_pkg::MAC_SUB;
            state_in      = T_X3;
         end
         // Park X = n*Syy - Sy^2, start Q*X
         T_X3: begin
            x_in          = X_W'(acc);
            op_a          = acc[31:0];
            op_b          = Q_OP;
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_Q1;
         end
         T_Q1: begin
            op_a          = x64[63:32];
            op_b          = Q_OP;
            mac_ctrl.mode = ltd_pkg::MAC_ADD;
            mac_ctrl.hi   = 1'b1;
            state_in      = T_Q2;
         end
         T_Q2: begin
            op_a          = MW'(dmag_ff);
            op_b          = MW'(dmag_ff);
            mac_ctrl.mode = ltd_pkg::MAC_SUB;
            state_in      = T_Q3;
         end
         // Clamp R at zero, start (n-2)*|D|
         T_Q3: begin
            r_in          = acc_sign ? '0 : R_W'(acc);
            op_a          = MW'(dmag_ff);
            op_b          = NM2_OP;
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_L0;
         end
         // Reuse the X register for (n-2)*|D|, start t^2 * R
         T_L0: begin
            x_in          = X_W'(acc);
            op_a          = MW'(crit_t2);
            op_b          = r64[31:0];
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_L1;
         end
         T_L1: begin
            op_a          = MW'(crit_t2);
            op_b          = r64[63:32];
            mac_ctrl.mode = ltd_pkg::MAC_ADD;
            mac_ctrl.hi   = 1'b1;
            state_in      = T_L2;
         end
         T_L2: begin
            rhs_in        = acc;
            op_a          = x_ff[31:0];
            op_b          = MW'(dmag_ff);
            mac_ctrl.mode = ltd_pkg::MAC_LOAD;
            state_in      = T_L3;
         end
         T_L3: begin
            done     = 1'b1;
            state_in = T_IDLE;
         end
         default: begin
            state_in = T_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= T_IDLE;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         j_ff     <= j_in;
      end
      sy_ff   <= sy_in;
      sxy_ff  <= sxy_in;
      syy_ff  <= syy_in;
      x_ff    <= x_in;
      r_ff    <= r_in;
      dmag_ff <= dmag_in;
      dneg_ff <= dneg_in;
      rhs_ff  <= rhs_in;
   end

endmodule

// ----- sv/light_trend_deploy_sequencer.sv -----
// Each light sample that is transferred in shifts into a window of the last WINDOW_LEN
// samples and yields one result: the trend (training, falling, steady, rising) and
// the deploy phase after this sample. Once the window is full, each sample runs the slope
// t-test: one 32x32 multiplier is stepped through a squaring step for each window sample,
// twelve further product steps and a final compare step. While the window is still
// filling, the sample goes straight to its result, with the trend set to training.
// req_tready is high only while no sample is in work; a finished result waits in the
// output register and does not hold off the next sample. Configuration must be written
// through csr_* while idle; the block itself does not enforce this.
// Depends on ltd_pkg, ltd_window, ltd_mac, ltd_trend and the assertion macros.
module light_trend_deploy_sequencer #(
   parameter int WINDOW_LEN = ltd_pkg::WINDOW_LEN_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // req_tdata: [15:0] lux_sample
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [ltd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: [1:0] trend_code, [3:2] payload_phase, [4] deploy_pulse, [7:5] zero
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ltd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                              csr_we,
   input  logic [ltd_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [ltd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

`include "light_trend_deploy_sequencer_macros.svh"

   localparam int ACC_W  = ltd_pkg::acc_width(WINDOW_LEN);
   localparam int FILL_W = $clog2(WINDOW_LEN + 1);
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WINDOW_LEN);
   localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(WINDOW_LEN - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_CALC,
      S_EMIT
   } state_type;

   state_type                          state_ff, state_in;
   logic [FILL_W-1:0]                  fill_ff, fill_in;
   ltd_pkg::phase_type                 phase_ff, phase_in;
   logic [ltd_pkg::LOW_LIGHT_W-1:0]    low_light_ff, low_light_in;
   logic [ltd_pkg::CRIT_T2_W-1:0]      crit_t2_ff, crit_t2_in;
   logic [ltd_pkg::LUX_W-1:0]          lux_ff, lux_in;
   ltd_pkg::trend_type                 trend_ff, trend_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   ltd_pkg::trend_type                 rsp_trend_ff, rsp_trend_in;
   ltd_pkg::phase_type                 rsp_phase_ff, rsp_phase_in;
   logic                               rsp_pulse_ff, rsp_pulse_in;

   logic                               accept;
   logic                               trend_start;
   logic                               trend_done;
   logic                               trend_rotate;
   ltd_pkg::trend_type                 trend_res;
   ltd_pkg::win_ctrl_type              win_ctrl;
   ltd_pkg::mac_ctrl_type              mac_ctrl;
   logic [ltd_pkg::MUL_W-1:0]          op_a;
   logic [ltd_pkg::MUL_W-1:0]          op_b;
   logic [ACC_W-1:0]                   acc;
   logic [ltd_pkg::LUX_W-1:0]          win_tail;
   ltd_pkg::phase_type                 phase_step;
   logic                               pulse_step;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_pulse_ff, rsp_phase_ff, rsp_trend_ff};

   assign win_ctrl.push   = accept;
   assign win_ctrl.rotate = trend_rotate;

   ltd_window #(
      .WINDOW_LEN (WINDOW_LEN)
   ) u_window (
      .clock (clock),
      .ctrl  (win_ctrl),
      .din   (req_tdata),
      .tail  (win_tail)
   );

   ltd_mac #(
      .ACC_W (ACC_W)
   ) u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   ltd_trend #(
      .WINDOW_LEN (WINDOW_LEN),
      .ACC_W      (ACC_W)
   ) u_trend (
      .clock    (clock),
      .reset    (reset),
      .start    (trend_start),
      .y        (win_tail),
      .crit_t2  (crit_t2_ff),
      .acc      (acc),
      .rotate   (trend_rotate),
      .mac_ctrl (mac_ctrl),
      .op_a     (op_a),
      .op_b     (op_b),
      .done     (trend_done),
      .trend    (trend_res)
   );

   // Phase chain: the three tests apply in order within one sample
   always_comb begin
      logic steady;
      logic below;
      logic above;
      steady     = (trend_ff == ltd_pkg::TREND_STEADY);
      below      = (lux_ff < low_light_ff);
      above      = (lux_ff > low_light_ff);
      phase_step = phase_ff;
      pulse_step = 1'b0;
      if (phase_step == ltd_pkg::PHASE_LOADING && below && steady) begin
         phase_step = ltd_pkg::PHASE_WAITING;
      end
      if (phase_step == ltd_pkg::PHASE_WAITING && above && steady) begin
         phase_step = ltd_pkg::PHASE_DEPLOYING;
         pulse_step = 1'b1;
      end
      if (phase_step == ltd_pkg::PHASE_DEPLOYING && above && steady) begin
         phase_step = ltd_pkg::PHASE_FINISHED;
      end
   end

   // Control: take a sample, run the test when the window is full, emit the result
   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      phase_in     = phase_ff;
      lux_in       = lux_ff;
      trend_in     = trend_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_trend_in = rsp_trend_ff;
      rsp_phase_in = rsp_phase_ff;
      rsp_pulse_in = rsp_pulse_ff;
      trend_start  = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               lux_in = req_tdata;
               if (fill_ff != FILL_FULL) begin
                  fill_in = fill_ff + FILL_W'(1);
               end
               if (fill_ff == FILL_FULL || fill_ff == FILL_LAST) begin
                  trend_start = 1'b1;
                  state_in    = S_CALC;
               end else begin
                  trend_in = ltd_pkg::TREND_TRAINING;
                  state_in = S_EMIT;
               end
            end
         end
         S_CALC: begin
            if (trend_done) begin
               trend_in = trend_res;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_trend_in = trend_ff;
               rsp_phase_in = phase_step;
               rsp_pulse_in = pulse_step;
               phase_in     = phase_step;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Register writes
   always_comb begin
      low_light_in = low_light_ff;
      crit_t2_in   = crit_t2_ff;
      if (csr_we) begin
         unique case (csr_index)
            ltd_pkg::CSR_LOW_LIGHT: low_light_in = csr_wdata[ltd_pkg::LOW_LIGHT_W-1:0];
            ltd_pkg::CSR_CRIT_T2:   crit_t2_in   = csr_wdata[ltd_pkg::CRIT_T2_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         fill_ff      <= '0;
         phase_ff     <= ltd_pkg::PHASE_LOADING;
         low_light_ff <= ltd_pkg::LOW_LIGHT_RESET;
         crit_t2_ff   <= ltd_pkg::CRIT_T2_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         phase_ff     <= phase_in;
         low_light_ff <= low_light_in;
         crit_t2_ff   <= crit_t2_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lux_ff       <= lux_in;
      trend_ff     <= trend_in;
      rsp_trend_ff <= rsp_trend_in;
      rsp_phase_ff <= rsp_phase_in;
      rsp_pulse_ff <= rsp_pulse_in;
   end

   // Checks
   `LTD_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_tready)
   `LTD_ASSERT_NEXT(a_finished_holds, clock, reset, phase_ff == ltd_pkg::PHASE_FINISHED, phase_ff == ltd_pkg::PHASE_FINISHED)
   `LTD_ASSERT_NOW(a_pulse_phase, clock, reset, rsp_valid_ff && rsp_pulse_ff, rsp_phase_ff == ltd_pkg::PHASE_DEPLOYING || rsp_phase_ff == ltd_pkg::PHASE_FINISHED)
   `LTD_ASSERT_NOW(a_done_in_calc, clock, reset, trend_done, state_ff == S_CALC)

endmodule
